// ===== hdl/bfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_pkg
// Types and constants shared by the batch frame deframer modules.
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam logic [4:0] HDR_BYTES = 5'd16;

    localparam logic [31:0] MAGIC_RST    = 32'h0000_0000;
    localparam logic [7:0]  VERSION_RST  = 8'd1;
    localparam logic [15:0] MAX_PKTS_RST = 16'd1024;

    typedef enum logic [1:0] {
        CFG_MAGIC    = 2'd0,
        CFG_VERSION  = 2'd1,
        CFG_MAX_PKTS = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_BODY   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_MAGIC     = 4'd2,
        ST_VERSION   = 4'd3,
        ST_COUNT     = 4'd4,
        ST_SEQUENCE  = 4'd5,
        ST_LENTRUNC  = 4'd6,
        ST_EMPTY     = 4'd7,
        ST_BODYTRUNC = 4'd8,
        ST_TRAILING  = 4'd9
    } status_t;

    // One queue entry: what a single payload byte caused.
    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic [15:0] body_index;
        logic        body_final;
        logic        end_valid;
        logic [7:0]  flags;
        logic [62:0] sequence_num;
        logic [15:0] count;
        status_t     status;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  packet_byte;
        logic [15:0] packet_index;
        logic        packet_final;
        logic [7:0]  batch_flags;
        logic [62:0] batch_sequence;
        logic [15:0] batch_count;
        status_t     batch_status;
        logic        run_last;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/bfd_intf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_intf
// Valid/ready channels for payload bytes in and result words out.
// ----------------------------------------------------------------------------
interface bfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_end;

    modport source (output valid, output payload_byte, output payload_end, input ready);
    modport sink   (input valid, input payload_byte, input payload_end, output ready);
endinterface

interface bfd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  packet_byte;
    logic [15:0] packet_index;
    logic        packet_final;
    logic [7:0]  batch_flags;
    logic [62:0] batch_sequence;
    logic [15:0] batch_count;
    logic [3:0]  batch_status;
    logic        run_last;

    modport source (
        output valid, output result_kind, output packet_byte, output packet_index,
        output packet_final, output batch_flags, output batch_sequence,
        output batch_count, output batch_status, output run_last, input ready
    );
    modport sink (
        input valid, input result_kind, input packet_byte, input packet_index,
        input packet_final, input batch_flags, input batch_sequence,
        input batch_count, input batch_status, input run_last, output ready
    );
endinterface
`default_nettype wire

// ===== hdl/bfd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_front
// Header and packet parser: takes one payload byte a cycle unless the queue is
// full, classifies it, queues what it causes (body word, batch end, or both).
// ----------------------------------------------------------------------------
module bfd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [31:0]     cfg_wdata,
    bfd_in_if.sink               pay,
    output logic                 push,
    output bfd_pkg::entry_t      push_data,
    input  bfd_pkg::q_stat_t     q_stat
);
    import bfd_pkg::*;

    logic [31:0] magic_word_reg;
    logic [7:0]  version_reg;
    logic [15:0] max_pkts_reg;

    phase_t      phase_reg,  phase_next,  phase_upd;
    logic [4:0]  pos_reg,    pos_next,    pos_upd;
    logic [31:0] magic_reg,  magic_next,  magic_upd;
    logic [7:0]  flags_reg,  flags_next,  flags_upd;
    logic [63:0] seq_reg,    seq_next,    seq_upd;
    logic [15:0] count_reg,  count_next,  count_upd;
    logic [15:0] done_reg,   done_next,   done_upd;
    logic [7:0]  lenhi_reg,  lenhi_next,  lenhi_upd;
    logic [15:0] rem_reg,    rem_next,    rem_upd;
    status_t     err_reg,    err_next,    err_upd;

    logic        accept;
    logic        emit;
    logic        fin;
    logic [7:0]  b;
    logic [31:0] magic_cat;
    logic [15:0] count_cat;
    logic [63:0] seq_cat;
    logic [15:0] len_cat;
    logic [15:0] rem_dec;
    logic [15:0] done_inc;
    logic [4:0]  pos_inc;
    status_t     status;

    assign b        = pay.payload_byte;
    assign pay.ready = !q_stat.full;
    assign accept   = pay.valid && !q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg <= MAGIC_RST;
            version_reg    <= VERSION_RST;
            max_pkts_reg   <= MAX_PKTS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAGIC:    magic_word_reg <= cfg_wdata;
                CFG_VERSION:  version_reg    <= cfg_wdata[7:0];
                CFG_MAX_PKTS: max_pkts_reg   <= cfg_wdata[15:0];
                default:      ;
            endcase
        end
    end

    // Next state: effect of the byte, then clear on the end mark.
    always_comb
    begin
        magic_cat = {magic_reg[23:0], b};
        count_cat = {count_reg[7:0], b};
        seq_cat   = {seq_reg[55:0], b};
        len_cat   = {lenhi_reg, b};
        rem_dec   = rem_reg - 16'd1;
        done_inc  = done_reg + 16'd1;
        pos_inc   = pos_reg + 5'd1;

        phase_upd = phase_reg;
        pos_upd   = pos_reg;
        magic_upd = magic_reg;
        flags_upd = flags_reg;
        seq_upd   = seq_reg;
        count_upd = count_reg;
        done_upd  = done_reg;
        lenhi_upd = lenhi_reg;
        rem_upd   = rem_reg;
        err_upd   = err_reg;
        emit      = 1'b0;
        fin       = 1'b0;

        if (phase_reg == PH_HEADER)
        begin
            // header bytes are counted even after an error
            if (pos_reg < 5'd4)
            begin
                magic_upd = magic_cat;
                if (pos_reg == 5'd3 && magic_cat != magic_word_reg && err_reg == ST_OK)
                    err_upd = ST_MAGIC;
            end
            else if (pos_reg == 5'd4)
            begin
                if (b != version_reg && err_reg == ST_OK)
                    err_upd = ST_VERSION;
            end
            else if (pos_reg == 5'd5)
            begin
                flags_upd = b;
            end
            else if (pos_reg < 5'd8)
            begin
                count_upd = count_cat;
                if (pos_reg == 5'd7 && err_reg == ST_OK
                    && (count_cat == 16'd0 || count_cat > max_pkts_reg))
                    err_upd = ST_COUNT;
            end
            else
            begin
                seq_upd = seq_cat;
                if (pos_reg == 5'd15 && seq_cat[63] && err_reg == ST_OK)
                    err_upd = ST_SEQUENCE;
            end
            pos_upd = pos_inc;
            if (pos_inc == HDR_BYTES)
                phase_upd = PH_LEN_HI;
        end
        else if (err_reg == ST_OK)
        begin
            case (phase_reg)
                PH_LEN_HI:
                begin
                    lenhi_upd = b;
                    phase_upd = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    rem_upd = len_cat;
                    if (len_cat == 16'd0)
                        err_upd = ST_EMPTY;
                    else
                        phase_upd = PH_BODY;
                end
                PH_BODY:
                begin
                    rem_upd = rem_dec;
                    emit    = 1'b1;
                    fin     = (rem_dec == 16'd0);
                    if (rem_dec == 16'd0)
                    begin
                        done_upd  = done_inc;
                        phase_upd = (done_inc == count_reg) ? PH_DONE : PH_LEN_HI;
                    end
                end
                default:
                    err_upd = ST_TRAILING;
            endcase
        end

        phase_next = phase_reg;
        pos_next   = pos_reg;
        magic_next = magic_reg;
        flags_next = flags_reg;
        seq_next   = seq_reg;
        count_next = count_reg;
        done_next  = done_reg;
        lenhi_next = lenhi_reg;
        rem_next   = rem_reg;
        err_next   = err_reg;
        if (accept)
        begin
            if (pay.payload_end)
            begin
                phase_next = PH_HEADER;
                pos_next   = '0;
                magic_next = '0;
                flags_next = '0;
                seq_next   = '0;
                count_next = '0;
                done_next  = '0;
                lenhi_next = '0;
                rem_next   = '0;
                err_next   = ST_OK;
            end
            else
            begin
                phase_next = phase_upd;
                pos_next   = pos_upd;
                magic_next = magic_upd;
                flags_next = flags_upd;
                seq_next   = seq_upd;
                count_next = count_upd;
                done_next  = done_upd;
                lenhi_next = lenhi_upd;
                rem_next   = rem_upd;
                err_next   = err_upd;
            end
        end
    end

    // Outputs: build the queue entry from the post-byte state.
    always_comb
    begin
        if (pos_upd < HDR_BYTES)
            status = ST_SHORT;
        else if (err_upd != ST_OK)
            status = err_upd;
        else if (phase_upd == PH_LEN_HI || phase_upd == PH_LEN_LO)
            status = ST_LENTRUNC;
        else if (phase_upd == PH_BODY)
            status = ST_BODYTRUNC;
        else
            status = ST_OK;

        push_data              = '0;
        push_data.body_valid   = emit;
        push_data.body_byte    = b;
        push_data.body_index   = done_reg;
        push_data.body_final   = fin;
        push_data.end_valid    = pay.payload_end;
        push_data.status       = status;
        if (status == ST_OK)
        begin
            push_data.flags        = flags_upd;
            push_data.sequence_num = seq_upd[62:0];
            push_data.count        = count_upd;
        end
        push = accept && (emit || pay.payload_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            magic_reg <= '0;
            flags_reg <= '0;
            seq_reg   <= '0;
            count_reg <= '0;
            done_reg  <= '0;
            lenhi_reg <= '0;
            rem_reg   <= '0;
            err_reg   <= ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            magic_reg <= magic_next;
            flags_reg <= flags_next;
            seq_reg   <= seq_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            lenhi_reg <= lenhi_next;
            rem_reg   <= rem_next;
            err_reg   <= err_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/bfd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_queue
// Short FIFO of parsed entries between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module bfd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  bfd_pkg::entry_t       push_data,
    input  wire logic             pop,
    output bfd_pkg::entry_t       head,
    output bfd_pkg::q_stat_t      stat
);
    import bfd_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));

endmodule
`default_nettype wire

// ===== hdl/bfd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_back
// Result sequencer: pops entries and, unless stalled, drives one result word a
// cycle via an output register, holding a batch end word behind a body word.
// ----------------------------------------------------------------------------
module bfd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  bfd_pkg::entry_t      head,
    input  bfd_pkg::q_stat_t     q_stat,
    output logic                 pop,
    bfd_out_if.source            res
);
    import bfd_pkg::*;

    logic    out_valid_reg,  out_valid_next;
    result_t out_reg,        out_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg,       pend_next;
    logic    out_free;

    function automatic result_t body_word(input entry_t e);
        result_t w;
        w              = '0;
        w.result_kind  = 1'b0;
        w.packet_byte  = e.body_byte;
        w.packet_index = e.body_index;
        w.packet_final = e.body_final;
        w.batch_status = ST_OK;
        w.run_last     = !e.end_valid;
        return w;
    endfunction

    function automatic result_t end_word(input entry_t e);
        result_t w;
        w                = '0;
        w.result_kind    = 1'b1;
        w.batch_flags    = e.flags;
        w.batch_sequence = e.sequence_num;
        w.batch_count    = e.count;
        w.batch_status   = e.status;
        w.run_last       = 1'b1;
        return w;
    endfunction

    always_comb
    begin
        out_free        = !out_valid_reg || res.ready;
        pop             = 1'b0;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                // drain the held batch end word first
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else if (!q_stat.empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (head.body_valid)
                begin
                    out_next = body_word(head);
                    if (head.end_valid)
                    begin
                        pend_valid_next = 1'b1;
                        pend_next       = end_word(head);
                    end
                end
                else
                begin
                    out_next = end_word(head);
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.result_kind    = out_reg.result_kind;
    assign res.packet_byte    = out_reg.packet_byte;
    assign res.packet_index   = out_reg.packet_index;
    assign res.packet_final   = out_reg.packet_final;
    assign res.batch_flags    = out_reg.batch_flags;
    assign res.batch_sequence = out_reg.batch_sequence;
    assign res.batch_count    = out_reg.batch_count;
    assign res.batch_status   = out_reg.batch_status;
    assign res.run_last       = out_reg.run_last;

endmodule
`default_nettype wire

// ===== hdl/batch_frame_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// batch_frame_deframer
// Checks a 16-byte batch header, walks length-prefixed packets and passes
// body bytes on, then reports a batch end word with status on the last byte.
// ----------------------------------------------------------------------------
//  channel   dir   handshake     word
//  payload   in    valid/ready   payload_byte, payload_end
//  result    out   valid/ready   body byte or batch end result
//  cfg_*     in    cfg_we        cfg_index selects magic, version, max packets
//
//  One payload byte is taken per cycle while the queue is not full; a result
//  word reaches the port through the queue write, then the output register.
//  A byte that ends a packet body and the payload gives two result words,
//  so the result port must pass two words for that byte; the queue absorbs it.
//  Payload ready drops only while the QUEUE_DEPTH-entry queue is full.
//  Reset clears the parser and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module batch_frame_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    bfd_in_if.sink           payload,
    bfd_out_if.source        result
);
    import bfd_pkg::*;

    logic    push;
    entry_t  push_data;
    logic    pop;
    entry_t  head;
    q_stat_t q_stat;

    bfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pay       (payload),
        .push      (push),
        .push_data (push_data),
        .q_stat    (q_stat)
    );

    bfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    bfd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .res    (result)
    );

    // A word that is not the last of its byte is followed by the batch end word.
    a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !result.run_last)
        |=> (result.valid && result.result_kind))
        else $error("batch end word did not follow a non-last word");

    // Header fields are reported only with a good status.
    a_fields_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.batch_status != ST_OK)
        |-> (result.batch_sequence == '0 && result.batch_flags == '0
             && result.batch_count == '0))
        else $error("header fields reported with an error status");

    // A fresh result word comes from a queue entry present the cycle before.
    a_rose_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(!q_stat.empty))
        else $error("result word appeared with an empty queue");

    // The queue never takes an entry while full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.full && !pop) |=> $stable(q_stat.full))
        else $error("queue state changed while full and not popped");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for batch_frame_deframer. Payload bytes are fed from a
// queue with random gaps while the result side stalls at random; every
// accepted byte is run through a bit-accurate model of the header checks and
// packet walk, and each result word is compared against the oldest
// prediction. Register settings change between traffic phases.
// ----------------------------------------------------------------------------
module tb;
    import bfd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;   // hold this byte until all results are back
    } payload_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    cfg_idx_t    cfg_index = CFG_MAGIC;
    logic [31:0] cfg_wdata = '0;

    logic       send_valid = 1'b0;
    logic [7:0] send_byte = '0;
    logic       send_end = 1'b0;
    logic       take_ready = 1'b0;

    bfd_in_if  byte_ch ();
    bfd_out_if word_ch ();

    assign byte_ch.valid        = send_valid;
    assign byte_ch.payload_byte = send_byte;
    assign byte_ch.payload_end  = send_end;
    assign word_ch.ready        = take_ready;

    batch_frame_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .payload   (byte_ch),
        .result    (word_ch)
    );

    always #4 clk = ~clk;

    // register copies
    logic [31:0] cfg_magic    = MAGIC_RST;
    logic [7:0]  cfg_version  = VERSION_RST;
    logic [15:0] cfg_max_pkts = MAX_PKTS_RST;

    // parser copy
    phase_t      parse_ph;
    logic [4:0]  hdr_pos;
    logic [31:0] magic_acc;
    logic [7:0]  flags_acc;
    logic [63:0] seq_acc;
    logic [15:0] count_acc;
    logic [15:0] pkts_done;
    logic [7:0]  len_hi;
    logic [15:0] body_left;
    status_t     first_err;

    result_t       expected_words[$];
    payload_item_t payload_items[$];
    logic [7:0]    frame[$];
    int            len_at[$];

    int bytes_queued = 0;
    int bytes_taken = 0;
    int words_seen = 0;
    int batch_ends = 0;
    int mismatches = 0;
    logic [9:0] status_seen = '0;

    int gap_left = 0;
    int stall_left = 0;
    bit no_idle = 1'b0;

    function automatic int pick_gap();
        int r;
        if ($urandom_range(199, 0) == 0)
            no_idle = !no_idle;
        if (no_idle)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic void reset_parser();
        parse_ph  = PH_HEADER;
        hdr_pos   = '0;
        magic_acc = '0;
        flags_acc = '0;
        seq_acc   = '0;
        count_acc = '0;
        pkts_done = '0;
        len_hi    = '0;
        body_left = '0;
        first_err = ST_OK;
    endfunction

    function automatic void note_error(status_t code);
        if (first_err == ST_OK)
            first_err = code;
    endfunction

    // Advance the parser copy by one payload byte and queue the words it causes.
    function automatic void deframe_byte(logic [7:0] b, logic last);
        result_t body_word;
        result_t end_word;
        status_t st;
        body_word = '0;
        end_word  = '0;
        if (parse_ph == PH_HEADER) begin
            if (hdr_pos < 5'd4) begin
                magic_acc = {magic_acc[23:0], b};
                if (hdr_pos == 5'd3 && magic_acc != cfg_magic)
                    note_error(ST_MAGIC);
            end
            else if (hdr_pos == 5'd4) begin
                if (b != cfg_version)
                    note_error(ST_VERSION);
            end
            else if (hdr_pos == 5'd5) begin
                flags_acc = b;
            end
            else if (hdr_pos < 5'd8) begin
                count_acc = {count_acc[7:0], b};
                if (hdr_pos == 5'd7 && (count_acc == 16'd0 || count_acc > cfg_max_pkts))
                    note_error(ST_COUNT);
            end
            else begin
                seq_acc = {seq_acc[55:0], b};
                if (hdr_pos == 5'd15 && seq_acc[63])
                    note_error(ST_SEQUENCE);
            end
            hdr_pos = hdr_pos + 5'd1;
            if (hdr_pos == HDR_BYTES)
                parse_ph = PH_LEN_HI;
        end
        else if (first_err == ST_OK) begin
            case (parse_ph)
                PH_LEN_HI:
                begin
                    len_hi   = b;
                    parse_ph = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    body_left = {len_hi, b};
                    if (body_left == 16'd0)
                        note_error(ST_EMPTY);
                    else
                        parse_ph = PH_BODY;
                end
                PH_BODY:
                begin
                    body_left = body_left - 16'd1;
                    body_word.packet_byte  = b;
                    body_word.packet_index = pkts_done;
                    body_word.packet_final = (body_left == 16'd0);
                    body_word.run_last     = !last;
                    expected_words = {expected_words, body_word};
                    if (body_left == 16'd0) begin
                        pkts_done = pkts_done + 16'd1;
                        parse_ph  = (pkts_done == count_acc) ? PH_DONE : PH_LEN_HI;
                    end
                end
                default:
                    note_error(ST_TRAILING);
            endcase
        end

        if (last) begin
            if (hdr_pos < HDR_BYTES)
                st = ST_SHORT;
            else if (first_err != ST_OK)
                st = first_err;
            else if (parse_ph == PH_LEN_HI || parse_ph == PH_LEN_LO)
                st = ST_LENTRUNC;
            else if (parse_ph == PH_BODY)
                st = ST_BODYTRUNC;
            else
                st = ST_OK;
            end_word.result_kind = 1'b1;
            if (st == ST_OK) begin
                end_word.batch_flags    = flags_acc;
                end_word.batch_sequence = seq_acc[62:0];
                end_word.batch_count    = count_acc;
            end
            end_word.batch_status = st;
            end_word.run_last     = 1'b1;
            expected_words = {expected_words, end_word};
            reset_parser();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH word %0d: %s got %0h want %0h", words_seen, what, got, want);
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        payload_item_t item;
        if (!rst_n) begin
            send_valid <= 1'b0;
            send_byte  <= '0;
            send_end   <= 1'b0;
            gap_left = 0;
        end
        else if (!send_valid || byte_ch.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                send_valid <= 1'b0;
            end
            else if (payload_items.size() > 0 &&
                     !(payload_items[0].drain &&
                       (expected_words.size() != 0 || (send_valid && byte_ch.ready)))) begin
                item = payload_items.pop_front();
                send_valid <= 1'b1;
                send_byte  <= item.data;
                send_end   <= item.last;
                gap_left = pick_gap();
            end
            else begin
                send_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check result words, predict from accepted payload bytes
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            take_ready <= 1'b0;
            stall_left = 0;
            reset_parser();
        end
        else begin
            if (word_ch.valid && word_ch.ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    report_mismatch("word with nothing pending, kind",
                                    64'(word_ch.result_kind), 64'd0);
                end
                else begin
                    want = expected_words.pop_front();
                    check_field("result_kind", 64'(word_ch.result_kind),
                                64'(want.result_kind));
                    check_field("packet_byte", 64'(word_ch.packet_byte),
                                64'(want.packet_byte));
                    check_field("packet_index", 64'(word_ch.packet_index),
                                64'(want.packet_index));
                    check_field("packet_final", 64'(word_ch.packet_final),
                                64'(want.packet_final));
                    check_field("batch_flags", 64'(word_ch.batch_flags),
                                64'(want.batch_flags));
                    check_field("batch_sequence", 64'(word_ch.batch_sequence),
                                64'(want.batch_sequence));
                    check_field("batch_count", 64'(word_ch.batch_count),
                                64'(want.batch_count));
                    check_field("batch_status", 64'(word_ch.batch_status),
                                64'(want.batch_status));
                    check_field("run_last", 64'(word_ch.run_last),
                                64'(want.run_last));
                    if (want.result_kind) begin
                        batch_ends++;
                        status_seen[want.batch_status] = 1'b1;
                    end
                end
            end
            if (byte_ch.valid && byte_ch.ready) begin
                bytes_taken++;
                deframe_byte(byte_ch.payload_byte, byte_ch.payload_end);
            end
            if (stall_left > 0) begin
                stall_left--;
                take_ready <= 1'b0;
            end
            else begin
                take_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAGIC:    cfg_magic = value;
            CFG_VERSION:  cfg_version = value[7:0];
            CFG_MAX_PKTS: cfg_max_pkts = value[15:0];
            default:      ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] magic, input logic [7:0] version,
                            input logic [15:0] max_pkts);
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_VERSION, {24'd0, version});
        write_reg(CFG_MAX_PKTS, {16'd0, max_pkts});
    endtask

    // Wait until every byte is taken and every word is back, then let the
    // pipeline drain before touching registers.
    task automatic settle();
        while (bytes_taken != bytes_queued || expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic void queue_frame(int hold_at);
        payload_item_t item;
        foreach (frame[i]) begin
            item.data  = frame[i];
            item.last  = (i == frame.size() - 1);
            item.drain = (i == hold_at);
            payload_items = {payload_items, item};
            bytes_queued++;
        end
    endfunction

    function automatic void trim_frame(int keep);
        while (frame.size() > keep)
            void'(frame.pop_back());
    endfunction

    // Build a well-formed batch for the current register settings.
    function automatic void build_batch(int npkts, int max_len);
        logic [63:0] seq;
        int len;
        seq = {$urandom, $urandom};
        seq[63] = 1'b0;
        frame.delete();
        len_at.delete();
        for (int i = 3; i >= 0; i--)
            frame = {frame, cfg_magic[8*i +: 8]};
        frame = {frame, cfg_version};
        frame = {frame, 8'($urandom)};
        frame = {frame, 8'(npkts >> 8)};
        frame = {frame, 8'(npkts)};
        for (int i = 7; i >= 0; i--)
            frame = {frame, seq[8*i +: 8]};
        for (int p = 0; p < npkts; p++) begin
            len = $urandom_range(max_len, 1);
            len_at = {len_at, frame.size()};
            frame = {frame, 8'(len >> 8)};
            frame = {frame, 8'(len)};
            repeat (len) frame = {frame, 8'($urandom)};
        end
    endfunction

    function automatic void random_batch();
        int sel;
        int npk;
        int pos;
        logic [15:0] bad_count;
        npk = $urandom_range((cfg_max_pkts >= 3 || cfg_max_pkts == 0) ? 3 : cfg_max_pkts, 1);
        build_batch(npk, ($urandom_range(9, 0) == 0) ? 40 : 5);
        sel = $urandom_range(99, 0);
        if (sel < 50) begin
            // well-formed
        end
        else if (sel < 55) begin
            frame[$urandom_range(3, 0)] ^= 8'(1 << $urandom_range(7, 0));
        end
        else if (sel < 58) begin
            frame[4] ^= 8'($urandom_range(255, 1));
        end
        else if (sel < 62) begin
            if (cfg_max_pkts == 16'hFFFF || $urandom_range(1, 0) == 0)
                bad_count = '0;
            else
                bad_count = 16'($urandom_range(65535, int'(cfg_max_pkts) + 1));
            frame[6] = bad_count[15:8];
            frame[7] = bad_count[7:0];
        end
        else if (sel < 65) begin
            frame[8] |= 8'h80;
        end
        else if (sel < 72) begin
            trim_frame($urandom_range(frame.size() - 1, 1));
        end
        else if (sel < 77) begin
            repeat ($urandom_range(3, 1)) frame = {frame, 8'($urandom)};
        end
        else if (sel < 81) begin
            pos = len_at[$urandom_range(len_at.size() - 1, 0)];
            frame[pos]     = 8'h00;
            frame[pos + 1] = 8'h00;
        end
        else if (sel < 87) begin
            // arbitrary count, cut somewhere after the header
            frame[6] = 8'($urandom);
            frame[7] = 8'($urandom);
            trim_frame($urandom_range(frame.size() - 1, 16));
        end
        else if (sel < 92) begin
            frame.delete();
            repeat ($urandom_range(24, 1)) frame = {frame, 8'($urandom)};
        end
        else begin
            repeat ($urandom_range(3, 1))
                frame[$urandom_range(frame.size() - 1, 0)] ^= 8'($urandom_range(255, 1));
            if ($urandom_range(1, 0) == 1)
                trim_frame($urandom_range(frame.size() - 1, 1));
        end
        queue_frame(($urandom_range(49, 0) == 0) ? $urandom_range(frame.size() - 1, 0) : -1);
    endfunction

    task automatic fill_random(input int target);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < target)
            random_batch();
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values: lone end byte, then a minimal good batch with
        // flags and sequence at their top values, pausing before the length
        frame = '{8'hFF};
        queue_frame(-1);
        frame = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h01,
                  8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, 8'h01, 8'h5A};
        queue_frame(16);
        fill_random(150);

        settle();
        set_regs($urandom, 8'($urandom), 16'd3);
        fill_random(180);

        settle();
        set_regs(32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        // full count and full length, cut inside the body
        frame = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'hFF, 8'hFF, 8'h00, 8'hFF};
        queue_frame(-1);
        fill_random(150);

        settle();
        set_regs(32'h0000_0000, 8'h00, 16'd1);
        fill_random(150);

        settle();
        set_regs($urandom, 8'($urandom), 16'd0);
        fill_random(60);

        settle();
        set_regs($urandom, 8'h01, 16'd1024);
        fill_random(180);

        settle();
        $display("covered %0d payload bytes, %0d result words, %0d batch ends",
                 bytes_taken, words_seen, batch_ends);
        $display("batch statuses seen (bit per code 9..0): %b", status_seen);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d words still pending", expected_words.size());
        $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bfd_pkg.sv
hdl/bfd_intf.sv
hdl/bfd_front.sv
hdl/bfd_queue.sv
hdl/bfd_back.sv
hdl/batch_frame_deframer.sv
tb/sv/tb.sv
